// ----- rtl/lcgrd_pkg.sv -----
`default_nettype none

package lcgrd_pkg;

    // generator constants
    localparam int unsigned MultWidth  = 35;
    localparam int unsigned StateWidth = 48;
    localparam logic [MultWidth-1:0]  LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [StateWidth-1:0] LCG_ADD  = 48'hB;

    // opcodes
    localparam logic OP_RAW     = 1'b0;
    localparam logic OP_BOUNDED = 1'b1;

    // register index of the seed
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_CHECK,
        S_OUT
    } t_fsm;

    typedef struct packed {
        logic load_item;
        logic mul_start;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_last;
        logic div_last;
        logic retry;
        logic is_direct;   // raw draw or power-of-two bound: no division
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/lcgrd_ctrl.sv -----
`default_nettype none

module lcgrd_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire                     i_out_ready,
    output logic                    o_out_valid,
    input  lcgrd_pkg::t_status      i_status,
    output lcgrd_pkg::t_cmd         o_cmd
);
    import lcgrd_pkg::*;

    t_fsm r_fsm, n_fsm;
    logic r_out_valid, n_out_valid;
    logic w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (i_in_valid) n_fsm = S_MUL;
            end
            S_MUL: begin
                if (i_status.mul_last) n_fsm = i_status.is_direct ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) n_fsm = S_CHECK;
            end
            S_CHECK: begin
                n_fsm = i_status.retry ? S_MUL : S_OUT;
            end
            S_OUT: begin
                if (w_slot_free) n_fsm = S_IDLE;
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_fsm)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
                o_cmd.mul_start = i_in_valid;
            end
            S_MUL: begin
                o_cmd.mul_step  = 1'b1;
                o_cmd.div_start = i_status.mul_last && !i_status.is_direct;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_CHECK: begin
                o_cmd.mul_start = i_status.retry;
            end
            S_OUT: begin
                o_cmd.out_load = w_slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/lcgrd_dpath.sv -----
`default_nettype none

module lcgrd_dpath (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  lcgrd_pkg::t_cmd         i_cmd,
    output lcgrd_pkg::t_status      o_status,
    input  wire                     i_opcode,
    input  wire  [5:0]              i_bit_count,
    input  wire  [30:0]             i_upper_bound,
    input  wire                     i_seed_we,
    input  wire  [47:0]             i_seed_wdata,
    output logic [47:0]             o_seed,
    output logic [31:0]             o_value
);
    import lcgrd_pkg::*;

    logic        r_op;
    logic [5:0]  r_nbits;
    logic [30:0] r_bound;
    logic [47:0] r_seed;
    logic [47:0] r_state;
    logic [47:0] r_acc;
    logic [1:0]  r_chunk;
    logic [30:0] r_rem;
    logic [4:0]  r_dcnt;
    logic [31:0] r_value;

    logic [15:0] w_chunk;
    logic [50:0] w_prod;
    logic [47:0] w_part;
    logic [47:0] n_acc;
    logic [30:0] w_draw;
    logic [31:0] w_trial;
    logic [31:0] w_diff;
    logic        w_ge;
    logic [30:0] n_rem;
    logic [32:0] w_span;
    logic        w_pow2;
    logic [61:0] w_pprod;
    logic [5:0]  w_nsat;
    logic [5:0]  w_shamt;
    logic [31:0] w_raw;
    logic [31:0] n_value;

    // 48x35 multiply mod 2^48, one 16-bit slice of the state per cycle
    always_comb begin
        case (r_chunk)
            2'd0:    w_chunk = r_state[15:0];
            2'd1:    w_chunk = r_state[31:16];
            default: w_chunk = r_state[47:32];
        endcase
    end

    assign w_prod = 51'(w_chunk) * 51'(LCG_MULT);
    assign w_part = w_prod[47:0] << {r_chunk, 4'b0000};
    assign n_acc  = r_acc + w_part;

    // draw31 is the top of the freshly advanced state
    assign w_draw = r_state[47:17];

    // restoring remainder, one dividend bit per cycle
    assign w_trial = {r_rem, w_draw[r_dcnt]};
    assign w_diff  = w_trial - {1'b0, r_bound};
    assign w_ge    = (w_trial >= {1'b0, r_bound});
    assign n_rem   = w_ge ? w_diff[30:0] : w_trial[30:0];

    // rejection test: draw - rem + bound - 1 must stay below 2^31
    assign w_span = {2'b00, w_draw} - {2'b00, r_rem} + {2'b00, r_bound} - 33'd1;

    assign w_pow2  = ((r_bound & (r_bound - 31'd1)) == 31'd0);
    assign w_pprod = 62'(r_bound) * 62'(w_draw);

    // raw draw: bit count saturates at 32, zero gives zero
    assign w_nsat  = (r_nbits > 6'd32) ? 6'd32 : r_nbits;
    assign w_shamt = 6'd32 - w_nsat;
    assign w_raw   = (w_nsat == 6'd0) ? 32'd0 : (r_state[47:16] >> w_shamt[4:0]);

    always_comb begin
        if (r_op == OP_RAW) begin
            n_value = w_raw;
        end else if (w_pow2) begin
            n_value = {1'b0, w_pprod[61:31]};
        end else begin
            n_value = {1'b0, r_rem};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_state <= 48'(LCG_MULT);
        end else if (i_seed_we) begin
            r_seed  <= i_seed_wdata;
            r_state <= i_seed_wdata ^ 48'(LCG_MULT);
        end else if (i_cmd.mul_step && r_chunk == 2'd2) begin
            r_state <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_opcode;
            r_nbits <= i_bit_count;
            r_bound <= i_upper_bound;
        end
        if (i_cmd.mul_start) begin
            r_acc <= LCG_ADD;
        end else if (i_cmd.mul_step) begin
            r_acc <= n_acc;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dcnt <= 5'd30;
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt - 5'd1;
        end
        if (i_cmd.out_load) begin
            r_value <= n_value;
        end
    end

    // chunk counter is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_cmd.mul_start) begin
            r_chunk <= '0;
        end else if (i_cmd.mul_step) begin
            r_chunk <= r_chunk + 2'd1;
        end
    end

    assign o_status.mul_last  = (r_chunk == 2'd2);
    assign o_status.div_last  = (r_dcnt == 5'd0);
    assign o_status.retry     = |w_span[32:31];
    assign o_status.is_direct = (r_op == OP_RAW) || w_pow2;

    assign o_seed  = r_seed;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/lcg48_random_draw_core.sv -----
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+------------------------------------
// request  | in        | i_in_valid / o_in_ready   | i_opcode, i_bit_count, i_upper_bound
// result   | out       | o_out_valid / i_out_ready | o_value
// config   | in        | psel/penable/pwrite/pready| paddr, pwdata -> prdata (seed, 0x0)
//
// Raw draws and power-of-two bounds pass from acceptance through the multiply step to the
// output step; the state update runs as three 16x35 partial products on one multiplier.
// Other bounds add a bit-serial remainder and a check step before output, and each
// rejected draw repeats the multiply, remainder and check steps.
// One transaction is in flight; a new one is accepted while the last result still waits.
// Reset is synchronous, active low; the state loads 0x5DEECE66D (seed zero).
`default_nettype none

module lcg48_random_draw_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request channel
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_opcode,
    input  wire  [5:0]  i_bit_count,
    input  wire  [30:0] i_upper_bound,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_value,
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import lcgrd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_seed_we;
    logic [47:0] w_seed;

    // registers sit at 8-byte spacing, paddr[3] is the register index
    assign pready    = 1'b1;
    assign w_seed_we = psel && penable && pwrite && (paddr[3] == REG_SEED);
    assign prdata    = (paddr[3] == REG_SEED) ? {16'h0000, w_seed} : 64'd0;

    // sequencer: walks multiply, divide, check and output steps
    lcgrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // generator state, multiplier, remainder unit, result register
    lcgrd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_opcode      (i_opcode),
        .i_bit_count   (i_bit_count),
        .i_upper_bound (i_upper_bound),
        .i_seed_we     (w_seed_we),
        .i_seed_wdata  (pwdata[47:0]),
        .o_seed        (w_seed),
        .o_value       (o_value)
    );

    // an accepted transaction blocks further requests in the cycle after it
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted twice in a row");

    // a result load always raises the output valid
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("result loaded but not presented");

    // result never loaded while multiplier or divider is busy
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(w_cmd.mul_step || w_cmd.div_step || w_cmd.mul_start))
        else $error("result loaded during computation");

endmodule

`default_nettype wire
